// ----- hw/rtl/lcfd_pkg.sv -----
// Shared constants and types for the length/checksum frame deframer.
package lcfd_pkg;

   localparam int MAX_FRAME_DEF = 64;   // default store depth and longest frame
   localparam int MIN_FRAME     = 6;    // head, two length bytes, command, checksum, tail
   localparam int HDR_LEN       = 3;    // head plus two length bytes
   localparam int CMD_OFF       = 3;
   localparam int PAY_OFF       = 4;
   localparam int TRAILER       = 2;    // checksum and tail

   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int FIELD6_W  = 6;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TAIL = CSR_IDX_W'(1);

   localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h55;

   typedef enum logic [STATUS_W-1:0] {
      FS_GOOD     = 2'd0,
      FS_TAIL_ERR = 2'd1,
      FS_SUM_ERR  = 2'd2
   } frame_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOP,
      S_SCAN,
      S_LEN_REQ,
      S_LEN_HI,
      S_LEN_LO,
      S_CMD,
      S_TAIL,
      S_CSUM,
      S_SUM,
      S_SUMCHK,
      S_EMIT,
      S_PAY
   } state_type;

endpackage

// ----- hw/rtl/lcfd_ifs.sv -----
// Word channels of the deframer: received bytes, results and register writes.
interface lcfd_req_if import lcfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcfd_rsp_if import lcfd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] frame_status;
   logic [BYTE_W-1:0]   command_code;
   logic                has_payload;
   logic [BYTE_W-1:0]   payload_byte;
   logic [FIELD6_W-1:0] payload_index;
   logic [FIELD6_W-1:0] payload_length;
   logic                last;

   modport source (output valid, output frame_status, output command_code,
                   output has_payload, output payload_byte, output payload_index,
                   output payload_length, output last, input ready);
   modport sink   (input valid, input frame_status, input command_code,
                   input has_payload, input payload_byte, input payload_index,
                   input payload_length, input last, output ready);
endinterface

interface lcfd_csr_if import lcfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/length_checksum_frame_deframer.sv -----
// Flow: each accepted byte starts a rescan once a minimum frame could be buffered; the scan skips
//   bytes ahead of a head and drops a head with a bad length; a completing byte's first result
//   word is registered after the tail check (on a tail error) or else after the checksum sum.
// Throughput: a new byte is accepted only once the sequencer is back in idle; results leave at
//   one word per cycle while the sink is ready, bounded by the single read port of the frame store.
// Reset: fill count, start pointer to zero, head/tail to 0xAA/0x55; store not cleared.
module length_checksum_frame_deframer import lcfd_pkg::*; #(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lcfd_req_if.sink   req_ch,
   lcfd_rsp_if.source rsp_ch,
   lcfd_csr_if.sink   csr_ch
);

   localparam int AW = $clog2(MAX_FRAME);       // store address
   localparam int CW = $clog2(MAX_FRAME + 1);   // fill count, offsets, frame length
   localparam int LW = 16;                      // length field on the wire

   // circular add: base < MAX_FRAME, off <= MAX_FRAME, so one correction suffices
   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW+1)'(base) + (CW+1)'(off);
      if (s >= (CW+1)'(MAX_FRAME)) s = s - (CW+1)'(MAX_FRAME);
      return s[AW-1:0];
   endfunction

   // ---------------- registers ----------------
   state_type          state_ff, state_in;
   logic [AW-1:0]      start_ff, start_in;     // store slot of the oldest buffered byte
   logic [CW-1:0]      fill_ff, fill_in;       // number of buffered bytes
   logic [CW-1:0]      k_ff, k_in;             // scan / sum / payload position
   logic [CW-1:0]      len_ff, len_in;         // validated frame length
   logic [BYTE_W-1:0]  hi_ff, hi_in;           // length high byte
   logic [BYTE_W-1:0]  cmd_ff, cmd_in;
   logic [BYTE_W-1:0]  csum_ff, csum_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   frame_status_type   status_ff, status_in;
   logic               emitted_ff, emitted_in; // a frame already reported for this byte
   logic [BYTE_W-1:0]  head_ff, tail_ff;
   logic [BYTE_W-1:0]  rd_data_ff;

   // output word register
   logic               out_valid_ff, out_valid_in;
   frame_status_type   out_status_ff, out_status_in;
   logic [BYTE_W-1:0]  out_cmd_ff, out_cmd_in;
   logic               out_has_ff, out_has_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic [FIELD6_W-1:0] out_idx_ff, out_idx_in;
   logic [FIELD6_W-1:0] out_len_ff, out_len_in;
   logic               out_last_ff, out_last_in;

   // ---------------- frame store ----------------
   logic [BYTE_W-1:0]  frame_mem [MAX_FRAME];
   logic [CW-1:0]      rd_off;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic               mem_we;

   logic               req_fire;
   logic               out_free;
   logic [CW-1:0]      fill_eff;
   logic [LW-1:0]      len_wire;
   logic [LW-1:0]      plen_wide;
   logic               pay_last;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   // a full store is emptied before the new byte lands (unreachable at legal lengths)
   assign fill_eff  = (fill_ff >= CW'(MAX_FRAME)) ? '0 : fill_ff;
   assign wr_addr   = wrap_add(start_ff, fill_eff);
   assign rd_addr   = wrap_add(start_ff, rd_off);
   assign mem_we    = req_fire;
   assign len_wire  = {hi_ff, rd_data_ff};
   assign plen_wide = LW'(len_ff) - LW'(MIN_FRAME);
   assign pay_last  = ((k_ff + CW'(1)) == (len_ff - CW'(MIN_FRAME)));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_addr] <= req_ch.rx_byte;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      hi_in         = hi_ff;
      cmd_in        = cmd_ff;
      csum_in       = csum_ff;
      sum_in        = sum_ff;
      status_in     = status_ff;
      emitted_in    = emitted_ff;
      rd_off        = '0;
      out_valid_in  = rsp_ch.ready ? 1'b0 : out_valid_ff;
      out_status_in = out_status_ff;
      out_cmd_in    = out_cmd_ff;
      out_has_in    = out_has_ff;
      out_byte_in   = out_byte_ff;
      out_idx_in    = out_idx_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               fill_in    = fill_eff + CW'(1);
               emitted_in = 1'b0;
               state_in   = S_LOOP;
            end
         end

         // top of the rescan loop: only look once a minimum frame could be there
         S_LOOP: begin
            k_in   = '0;
            rd_off = '0;
            state_in = (fill_ff >= CW'(MIN_FRAME)) ? S_SCAN : S_IDLE;
         end

         // rd_data_ff holds byte k; hunt for the head
         S_SCAN: begin
            if (rd_data_ff == head_ff) begin
               start_in = wrap_add(start_ff, k_ff);
               fill_in  = fill_ff - k_ff;
               state_in = ((fill_ff - k_ff) < CW'(HDR_LEN)) ? S_IDLE : S_LEN_REQ;
            end else if ((k_ff + CW'(1)) == fill_ff) begin
               fill_in  = '0;                 // no head anywhere: drop everything
               state_in = S_IDLE;
            end else begin
               k_in   = k_ff + CW'(1);
               rd_off = k_ff + CW'(1);
            end
         end

         S_LEN_REQ: begin
            rd_off   = CW'(1);
            state_in = S_LEN_HI;
         end

         S_LEN_HI: begin
            hi_in    = rd_data_ff;
            rd_off   = CW'(2);
            state_in = S_LEN_LO;
         end

         S_LEN_LO: begin
            if (len_wire > LW'(MAX_FRAME) || len_wire < LW'(MIN_FRAME)) begin
               // bad length: drop this head and rescan
               start_in = wrap_add(start_ff, CW'(1));
               fill_in  = fill_ff - CW'(1);
               state_in = S_LOOP;
            end else if (LW'(fill_ff) < len_wire) begin
               state_in = S_IDLE;             // frame not complete yet
            end else if (emitted_ff) begin
               // second frame on one byte: consumed silently
               start_in = wrap_add(start_ff, len_wire[CW-1:0]);
               fill_in  = fill_ff - len_wire[CW-1:0];
               state_in = S_LOOP;
            end else begin
               len_in   = len_wire[CW-1:0];
               rd_off   = CW'(CMD_OFF);
               state_in = S_CMD;
            end
         end

         S_CMD: begin
            cmd_in   = rd_data_ff;
            rd_off   = len_ff - CW'(1);
            state_in = S_TAIL;
         end

         S_TAIL: begin
            if (rd_data_ff != tail_ff) begin
               status_in = FS_TAIL_ERR;
               state_in  = S_EMIT;
            end else begin
               rd_off   = len_ff - CW'(TRAILER);
               state_in = S_CSUM;
            end
         end

         S_CSUM: begin
            csum_in  = rd_data_ff;
            k_in     = '0;
            sum_in   = '0;
            rd_off   = '0;
            state_in = S_SUM;
         end

         // mod-256 sum over head through last payload byte, one byte a cycle
         S_SUM: begin
            sum_in = sum_ff + rd_data_ff;
            if ((k_ff + CW'(1)) == (len_ff - CW'(TRAILER))) begin
               state_in = S_SUMCHK;
            end else begin
               k_in   = k_ff + CW'(1);
               rd_off = k_ff + CW'(1);
            end
         end

         S_SUMCHK: begin
            if (sum_ff != csum_ff) begin
               status_in = FS_SUM_ERR;
               state_in  = S_EMIT;
            end else if (len_ff == CW'(MIN_FRAME)) begin
               status_in = FS_GOOD;
               state_in  = S_EMIT;
            end else begin
               k_in     = '0;
               rd_off   = CW'(PAY_OFF);
               state_in = S_PAY;
            end
         end

         // single word: error frame or good frame without payload
         S_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_cmd_in    = cmd_ff;
               out_has_in    = 1'b0;
               out_byte_in   = '0;
               out_idx_in    = '0;
               out_len_in    = plen_wide[FIELD6_W-1:0];
               out_last_in   = 1'b1;
               start_in      = wrap_add(start_ff, len_ff);
               fill_in       = fill_ff - len_ff;
               emitted_in    = 1'b1;
               state_in      = S_LOOP;
            end
         end

         // payload run; rd_data_ff holds byte PAY_OFF + k and is re-read while stalled
         S_PAY: begin
            rd_off = CW'(PAY_OFF) + k_ff;
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = FS_GOOD;
               out_cmd_in    = cmd_ff;
               out_has_in    = 1'b1;
               out_byte_in   = rd_data_ff;
               out_idx_in    = FIELD6_W'(k_ff);
               out_len_in    = plen_wide[FIELD6_W-1:0];
               out_last_in   = pay_last;
               if (pay_last) begin
                  start_in   = wrap_add(start_ff, len_ff);
                  fill_in    = fill_ff - len_ff;
                  emitted_in = 1'b1;
                  state_in   = S_LOOP;
               end else begin
                  k_in   = k_ff + CW'(1);
                  rd_off = CW'(PAY_OFF) + k_ff + CW'(1);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         fill_ff      <= '0;
         emitted_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         head_ff      <= HEAD_RESET;
         tail_ff      <= TAIL_RESET;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         fill_ff      <= fill_in;
         emitted_ff   <= emitted_in;
         out_valid_ff <= out_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_HEAD: head_ff <= csr_ch.data;
               CSR_TAIL: tail_ff <= csr_ch.data;
               default:  ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      len_ff        <= len_in;
      hi_ff         <= hi_in;
      cmd_ff        <= cmd_in;
      csum_ff       <= csum_in;
      sum_ff        <= sum_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_cmd_ff    <= out_cmd_in;
      out_has_ff    <= out_has_in;
      out_byte_ff   <= out_byte_in;
      out_idx_ff    <= out_idx_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.frame_status   = out_status_ff;
   assign rsp_ch.command_code   = out_cmd_ff;
   assign rsp_ch.has_payload    = out_has_ff;
   assign rsp_ch.payload_byte   = out_byte_ff;
   assign rsp_ch.payload_index  = out_idx_ff;
   assign rsp_ch.payload_length = out_len_ff;
   assign rsp_ch.last           = out_last_ff;

   // ---------------- assertions ----------------
   // the store never holds more than its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_FRAME))
      else $error("fill count above store depth");

   // an accepted byte always starts a rescan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_LOOP)
      else $error("accepted byte did not start a scan");

   // a word without payload is always a complete single-word run
   a_nopay_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.has_payload |-> rsp_ch.last)
      else $error("empty or error word not marked last");

   // the last payload word sits at the end of the payload
   a_pay_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.has_payload && rsp_ch.last |->
         (rsp_ch.payload_index + FIELD6_W'(1)) == rsp_ch.payload_length)
      else $error("payload run ended at wrong index");

endmodule
